/* rtl/core/lmmgr_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// Looping music mixer package
// Shared types, command codes and arithmetic constants for the mixer core.
// ============================================================================
package lmmgr_pkg;

   // Default depth of the music store (a power of two).
   localparam int unsigned STORE_DEPTH_DEFAULT = 65536;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = 17;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACK_LENGTH     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASTER_VOLUME    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_INTENSITY = 2'd2;

   // Reset values and the intensity ramp step (Q2.14).
   localparam logic [15:0] INTENSITY_RESET = 16'd16384;
   localparam logic [15:0] INTENSITY_STEP  = 16'd82;
   localparam logic [6:0]  VOLUME_RESET    = 7'd100;

   // The mix divisor is 2^16 * 50. The shift takes the power of two, and the
   // divide by 50 is a multiply by ceil(2^28 / 50), exact for quotients
   // below 2^28 / 44, well above the largest that can occur.
   localparam int unsigned DIV_SHIFT   = 16;
   localparam int unsigned RECIP_SHIFT = 28;
   localparam logic [22:0] RECIP_50    = 23'd5368710;

   // Saturation limits for the mixed sum.
   localparam logic signed [18:0] MIX_SAT_MAX = 19'sd32767;
   localparam logic signed [18:0] MIX_SAT_MIN = -19'sd32768;

   // Input item commands.
   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_MIX   = 2'd1,
      CMD_START = 2'd2
   } cmd_type;

   // Control sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_RUN   = 2'd1,
      ST_DRAIN = 2'd2
   } state_type;

   // Operands handed to the scaling pipeline.
   typedef struct packed {
      logic               start;
      logic [6:0]         volume;
      logic [15:0]        intensity;
      logic signed [15:0] sample;
   } scale_req_type;

   // Result of the scaling pipeline.
   typedef struct packed {
      logic               done;
      logic signed [15:0] mixed;
   } scale_rsp_type;

endpackage

/* rtl/core/lmmgr_store.sv */
`timescale 1ns / 1ps
// ============================================================================
// Music store
// Single-port-write, single-port-read synchronous memory with registered
// read data.
// ============================================================================
module lmmgr_store #(
   parameter int unsigned STORE_DEPTH = lmmgr_pkg::STORE_DEPTH_DEFAULT,
   parameter int unsigned ADDR_W      = $clog2(STORE_DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [15:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]       rd_data_ff
);
   import lmmgr_pkg::*;

   logic [15:0] mem [STORE_DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

/* rtl/core/lmmgr_scale.sv */
`timescale 1ns / 1ps
// ============================================================================
// Music scaling pipeline
// Four stages: gain product, music magnitude times gain, divide by the mix
// divisor through a reciprocal multiply, then sign, add and saturate.
// ============================================================================
module lmmgr_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  lmmgr_pkg::scale_req_type req,
   input  logic signed [15:0]      music,
   output lmmgr_pkg::scale_rsp_type rsp
);
   import lmmgr_pkg::*;

   // Stage valid flags.
   logic v1_ff, v2_ff, v3_ff, done_ff;

   // Stage payload.
   logic [22:0]        gain_ff;
   logic [15:0]        mag1_ff;
   logic               neg1_ff, neg2_ff, neg3_ff;
   logic signed [15:0] sample1_ff, sample2_ff, sample3_ff;
   logic [38:0]        prod_ff;
   logic [16:0]        quot_ff;
   logic signed [15:0] mixed_ff;

   // Combinational terms of each stage.
   logic [15:0]        music_mag_w;
   logic [22:0]        gain_w;
   logic [45:0]        recip_prod_w;
   logic signed [18:0] quot_ext_w;
   logic signed [18:0] scaled_w;
   logic signed [18:0] sum_w;
   logic signed [15:0] sat_w;

   // Stage 1 operands: music magnitude and volume times intensity.
   assign music_mag_w = music[15] ? 16'(-music) : 16'(music);
   assign gain_w      = 23'(req.volume) * 23'(req.intensity);

   // Stage 3 operand: floor(prod / 2^16) times the reciprocal of 50.
   assign recip_prod_w = 46'(prod_ff[38:DIV_SHIFT]) * 46'(RECIP_50);

   // Stage 4: restore the sign, add the sample and saturate.
   assign quot_ext_w = $signed({2'b00, quot_ff});
   assign scaled_w   = neg3_ff ? -quot_ext_w : quot_ext_w;
   assign sum_w      = 19'(sample3_ff) + scaled_w;

   always_comb begin
      priority if (sum_w > MIX_SAT_MAX) begin
         sat_w = 16'sh7FFF;
      end else if (sum_w < MIX_SAT_MIN) begin
         sat_w = 16'sh8000;
      end else begin
         sat_w = sum_w[15:0];
      end
   end

   // Valid chain through the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= req.start;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         done_ff <= v3_ff;
      end
   end

   // Stage payload registers; the final result holds until the next item.
   always_ff @(posedge clock) begin
      if (req.start) begin
         gain_ff    <= gain_w;
         mag1_ff    <= music_mag_w;
         neg1_ff    <= music[15];
         sample1_ff <= req.sample;
      end
      if (v1_ff) begin
         prod_ff    <= 39'(mag1_ff) * 39'(gain_ff);
         neg2_ff    <= neg1_ff;
         sample2_ff <= sample1_ff;
      end
      if (v2_ff) begin
         quot_ff    <= recip_prod_w[RECIP_SHIFT+16:RECIP_SHIFT];
         neg3_ff    <= neg2_ff;
         sample3_ff <= sample2_ff;
      end
      if (v3_ff) begin
         mixed_ff <= sat_w;
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.mixed = mixed_ff;

endmodule

/* rtl/core/looping_music_mixer_gain_ramp_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// Looping music mixer with gain ramp
// Mixes a looping music track from an on-chip store into a sample stream,
// scaled by volume and a slewed intensity, with 16-bit saturation.
// ============================================================================
//
//   Channel   Direction  Handshake                 Payload
//   req_      in         req_valid / req_stall     cmd, load address/sample,
//                                                   mix sample, block start
//   rsp_      out        rsp_valid / rsp_stall     mixed sample
//   csr_      in         csr_write_en              index, write data
//
// Load, start and pass-through mix items complete at their transfer edge. A
// mix item that plays music reads the store at its transfer edge, then passes
// the four stages of the scaling pipeline before its result is loaded into
// the output register. The input stalls until then.
// Reset is synchronous; the music store is not cleared and needs no sweep.
// A stalled result waits in the output register while the next item is taken;
// a second result then holds the sequencer until the register frees.
// STORE_DEPTH must be a power of two.
module looping_music_mixer_gain_ramp_core #(
   parameter int unsigned STORE_DEPTH = lmmgr_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input items.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_cmd,
   input  logic [15:0]                         req_load_address,
   input  logic signed [15:0]                  req_load_sample,
   input  logic signed [15:0]                  req_mix_sample,
   input  logic                                req_block_start,
   // Results.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [15:0]                  rsp_mixed_sample,
   // Configuration writes.
   input  logic                                csr_write_en,
   input  logic [lmmgr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lmmgr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lmmgr_pkg::*;

   localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);

   // Configuration registers.
   logic [16:0] track_length_ff;
   logic [6:0]  master_volume_ff;
   logic [15:0] target_intensity_ff;

   // Playback state.
   logic [16:0] pos_ff, pos_in;
   logic [15:0] intensity_ff, intensity_in;
   logic        playing_ff;
   state_type   state_ff, state_in;
   logic        kick_ff;
   logic signed [15:0] sample_ff;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff;

   // Control terms.
   cmd_type            cmd_w;
   logic               accept_w;
   logic               mix_active_w;
   logic               out_free_w;
   logic               out_load_w;
   logic signed [15:0] out_value_w;
   logic               play_w;
   logic [16:0]        pos_wrap_w;
   logic               store_wr_w;

   // Store and pipeline connections.
   logic [15:0]   store_rd_data;
   scale_req_type scale_req;
   scale_rsp_type scale_rsp;

   // One ramp step of the intensity toward the target, without overshoot.
   function automatic logic [15:0] slew_step(input logic [15:0] cur,
                                             input logic [15:0] tgt);
      logic [16:0] up;
      logic [15:0] gap;
      up  = {1'b0, cur} + 17'(INTENSITY_STEP);
      gap = cur - tgt;
      if (cur < tgt) begin
         slew_step = (up > {1'b0, tgt}) ? tgt : up[15:0];
      end else if (cur > tgt) begin
         slew_step = (gap <= INTENSITY_STEP) ? tgt : cur - INTENSITY_STEP;
      end else begin
         slew_step = cur;
      end
   endfunction

   assign cmd_w        = cmd_type'(req_cmd);
   assign mix_active_w = playing_ff && (track_length_ff != 17'd0);
   assign out_free_w   = !rsp_valid_ff || !rsp_stall;
   assign accept_w     = req_valid && !req_stall;

   // Position wraps to the start before the read.
   assign pos_wrap_w = (pos_ff >= track_length_ff) ? 17'd0 : pos_ff;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_w && cmd_w == CMD_MIX && mix_active_w) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (scale_rsp.done) begin
               state_in = out_free_w ? ST_IDLE : ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free_w) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: input stall, item decode and output register load.
   always_comb begin
      req_stall   = 1'b1;
      store_wr_w  = 1'b0;
      play_w      = 1'b0;
      out_load_w  = 1'b0;
      out_value_w = scale_rsp.mixed;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = (cmd_w == CMD_MIX) && !mix_active_w && !out_free_w;
            if (accept_w) begin
               unique case (cmd_w)
                  CMD_LOAD: begin
                     store_wr_w = 1'b1;
                  end
                  CMD_MIX: begin
                     if (mix_active_w) begin
                        play_w = 1'b1;
                     end else begin
                        out_load_w  = 1'b1;
                        out_value_w = req_mix_sample;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            out_load_w = scale_rsp.done && out_free_w;
         end
         ST_DRAIN: begin
            out_load_w = out_free_w;
         end
         default: begin
         end
      endcase
   end

   // Intensity and position updates for a playing mix item.
   assign intensity_in = req_block_start ? slew_step(intensity_ff, target_intensity_ff)
                                         : intensity_ff;
   assign pos_in       = pos_wrap_w + 17'd1;

   // Output register valid: set on a new result, cleared by a transfer.
   assign rsp_valid_in = out_load_w || (rsp_valid_ff && rsp_stall);

   // Control and configuration state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         kick_ff             <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         pos_ff              <= 17'd0;
         intensity_ff        <= INTENSITY_RESET;
         playing_ff          <= 1'b0;
         track_length_ff     <= 17'd0;
         master_volume_ff    <= VOLUME_RESET;
         target_intensity_ff <= INTENSITY_RESET;
      end else begin
         state_ff     <= state_in;
         kick_ff      <= play_w;
         rsp_valid_ff <= rsp_valid_in;
         if (accept_w && cmd_w == CMD_START) begin
            pos_ff     <= 17'd0;
            playing_ff <= 1'b1;
         end else if (play_w) begin
            pos_ff       <= pos_in;
            intensity_ff <= intensity_in;
         end
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_TRACK_LENGTH: begin
                  track_length_ff <= csr_wdata;
               end
               CSR_MASTER_VOLUME: begin
                  master_volume_ff <= csr_wdata[6:0];
               end
               CSR_TARGET_INTENSITY: begin
                  target_intensity_ff <= csr_wdata[15:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (play_w) begin
         sample_ff <= req_mix_sample;
      end
      if (out_load_w) begin
         rsp_sample_ff <= out_value_w;
      end
   end

   // Music store.
   lmmgr_store #(
      .STORE_DEPTH(STORE_DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (store_wr_w),
      .wr_addr   (ADDR_W'(req_load_address)),
      .wr_data   (req_load_sample),
      .rd_en     (play_w),
      .rd_addr   (ADDR_W'(pos_wrap_w)),
      .rd_data_ff(store_rd_data)
   );

   // Scaling pipeline, started once the store data is out.
   assign scale_req.start     = kick_ff;
   assign scale_req.volume    = master_volume_ff;
   assign scale_req.intensity = intensity_ff;
   assign scale_req.sample    = sample_ff;

   lmmgr_scale u_scale (
      .clock(clock),
      .reset(reset),
      .req  (scale_req),
      .music($signed(store_rd_data)),
      .rsp  (scale_rsp)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_sample_ff;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// Testbench for the looping music mixer core
// Runs a short table of directed items and then random phases of loads,
// starts and mixes under changing settings. Both channels idle in random
// bursts, and every mixed sample is checked against a behavioral model of
// the mixer kept in this file.
// ============================================================================
module tb_top;
   import lmmgr_pkg::*;

   localparam int unsigned DEPTH       = STORE_DEPTH_DEFAULT;
   localparam logic [1:0]  CMD_UNUSED  = 2'd3;
   // 50 percent base level, volume in percent, gain in Q2.14.
   localparam longint      MIX_DIVISOR = 3276800;
   // Quiet cycles after the last result, well above the latency of a mix item.
   localparam int unsigned SETTLE      = 12;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned PHASES      = 10;
   localparam int unsigned PHASE_ITEMS = 100;

   // One row of the directed table: a register write or an input item.
   typedef struct {
      bit                     is_write;
      logic [CSR_INDEX_W-1:0] reg_index;
      int unsigned            reg_value;
      logic [1:0]             cmd;
      logic [15:0]            addr;
      logic signed [15:0]     load_s;
      logic signed [15:0]     mix_s;
      logic                   blk;
      bit                     typed;
      logic signed [15:0]     typed_val;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [1:0]             req_cmd;
   logic [15:0]            req_load_address;
   logic signed [15:0]     req_load_sample;
   logic signed [15:0]     req_mix_sample;
   logic                   req_block_start;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic signed [15:0]     rsp_mixed_sample;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Mixer model state and settings.
   logic signed [15:0] track_words [DEPTH];
   bit                 word_loaded [DEPTH];
   int unsigned        play_pos;
   int unsigned        gain_now;
   bit                 is_playing;
   int unsigned        cfg_length;
   int unsigned        cfg_volume;
   int unsigned        cfg_target;

   logic signed [15:0] mixed_due [$];
   int unsigned        fail_count = 0;
   bit                 hold_pending = 1'b0;
   bit                 pressing = 1'b0;
   bit                 quiet = 1'b0;

   looping_music_mixer_gain_ramp_core #(
      .STORE_DEPTH(DEPTH)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_load_address (req_load_address),
      .req_load_sample  (req_load_sample),
      .req_mix_sample   (req_mix_sample),
      .req_block_start  (req_block_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mixed_sample (rsp_mixed_sample),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Advances the model by one accepted item; returns 1 when it gives a result.
   function automatic bit step_mixer(input logic [1:0] cmd, input logic [15:0] addr,
         input logic signed [15:0] load_s, input logic signed [15:0] mix_s,
         input logic blk, output logic signed [15:0] mixed);
      longint music;
      longint total;
      mixed = mix_s;
      if (cmd == CMD_LOAD) begin
         track_words[addr] = load_s;
         word_loaded[addr] = 1'b1;
         return 1'b0;
      end
      if (cmd == CMD_START) begin
         play_pos = 0;
         is_playing = 1'b1;
         return 1'b0;
      end
      if (cmd != CMD_MIX) return 1'b0;
      // Without a track to play the sample passes through and the gain holds.
      if (!is_playing || cfg_length == 0) return 1'b1;
      // A block start slews the gain one step toward the target, never past it.
      if (blk) begin
         if (gain_now < cfg_target) begin
            gain_now = (gain_now + INTENSITY_STEP > cfg_target) ? cfg_target
                                                                : gain_now + INTENSITY_STEP;
         end else if (gain_now > cfg_target) begin
            gain_now = (gain_now - cfg_target <= INTENSITY_STEP) ? cfg_target
                                                                 : gain_now - INTENSITY_STEP;
         end
      end
      if (play_pos >= cfg_length) play_pos = 0;
      music = track_words[play_pos % DEPTH];
      total = longint'(mix_s)
            + music * longint'(cfg_volume) * longint'(gain_now) / MIX_DIVISOR;
      if (total > MIX_SAT_MAX) total = MIX_SAT_MAX;
      if (total < MIX_SAT_MIN) total = MIX_SAT_MIN;
      mixed = total[15:0];
      play_pos = (play_pos + 1) & 32'h1FFFF;
      return 1'b1;
   endfunction

   function automatic plan_row_type item_row(input logic [1:0] cmd, input logic [15:0] addr,
         input logic signed [15:0] load_s, input logic signed [15:0] mix_s,
         input logic blk, input bit typed, input logic signed [15:0] typed_val);
      plan_row_type r;
      r = '{default: '0};
      r.cmd = cmd;
      r.addr = addr;
      r.load_s = load_s;
      r.mix_s = mix_s;
      r.blk = blk;
      r.typed = typed;
      r.typed_val = typed_val;
      return r;
   endfunction

   function automatic plan_row_type reg_row(input logic [CSR_INDEX_W-1:0] idx,
         input int unsigned value);
      plan_row_type r;
      r = '{default: '0};
      r.is_write = 1'b1;
      r.reg_index = idx;
      r.reg_value = value;
      return r;
   endfunction

   // Random sample word, with the two extremes turning up often.
   function automatic logic signed [15:0] random_word();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         default: return 16'($urandom());
      endcase
   endfunction

   // Offers one item from a falling edge and waits for its transfer.
   task automatic send_item(input logic [1:0] cmd, input logic [15:0] addr,
         input logic signed [15:0] load_s, input logic signed [15:0] mix_s,
         input logic blk, input bit typed, input logic signed [15:0] typed_val);
      logic signed [15:0] mixed;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_load_address <= addr;
      req_load_sample <= load_s;
      req_mix_sample <= mix_s;
      req_block_start <= blk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (step_mixer(cmd, addr, load_s, mix_s, blk, mixed))
         mixed_due.push_back(typed ? typed_val : mixed);
      @(negedge clock);
   endtask

   // Stops offering and waits until every expected sample has come out.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (mixed_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int unsigned value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_TRACK_LENGTH:  cfg_length = value & 32'h1FFFF;
         CSR_MASTER_VOLUME: cfg_volume = value & 32'h7F;
         default:           cfg_target = value & 32'hFFFF;
      endcase
   endtask

   // Draws new settings, the extremes among them, and writes all three registers.
   task automatic random_settings();
      int unsigned len;
      int unsigned vol;
      int          tgt;
      case ($urandom_range(0, 9))
         0: len = 0;
         1: len = 65536;
         2: len = 65535;
         3: len = 1;
         default: len = $urandom_range(2, 64);
      endcase
      case ($urandom_range(0, 5))
         0: vol = 0;
         1: vol = 100;
         2: vol = 127;
         default: vol = $urandom_range(0, 127);
      endcase
      case ($urandom_range(0, 5))
         0: tgt = 0;
         1: tgt = 65535;
         2: tgt = INTENSITY_RESET;
         // Close to the present gain, so that a step lands exactly on the target.
         3: tgt = int'(gain_now) - 80 + int'($urandom_range(0, 160));
         default: tgt = $urandom_range(0, 65535);
      endcase
      if (tgt < 0) tgt = 0;
      if (tgt > 65535) tgt = 65535;
      write_reg(CSR_TRACK_LENGTH, len);
      write_reg(CSR_MASTER_VOLUME, vol);
      write_reg(CSR_TARGET_INTENSITY, tgt);
   endtask

   // Mostly mixes and loads of the playing track, some starts and a few unused commands.
   task automatic random_phase(input int unsigned count);
      int unsigned        sent;
      int unsigned        pick;
      logic [15:0]        slot;
      logic [15:0]        addr;
      logic signed [15:0] load_s;
      logic signed [15:0] mix_s;
      logic               blk;
      sent = 0;
      while (sent < count) begin
         if (!quiet && !pressing && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         pick = $urandom_range(0, 99);
         load_s = random_word();
         mix_s = random_word();
         blk = ($urandom_range(0, 2) == 0);
         addr = 16'($urandom());
         slot = (play_pos >= cfg_length) ? 16'd0 : play_pos[15:0];
         if (pick < 62 && is_playing && cfg_length != 0 && !word_loaded[slot]) begin
            // Fill the word that the next mix will play before it is read.
            send_item(CMD_LOAD, slot, load_s, mix_s, blk, 1'b0, '0);
            sent++;
         end else if (pick < 62) begin
            send_item(CMD_MIX, addr, load_s, mix_s, blk, 1'b0, '0);
            sent++;
         end else if (pick < 90) begin
            if (cfg_length != 0 && $urandom_range(0, 3) != 0)
               addr = 16'($urandom_range(0, cfg_length - 1));
            send_item(CMD_LOAD, addr, load_s, mix_s, blk, 1'b0, '0);
            sent++;
         end else if (pick < 95) begin
            send_item(CMD_START, addr, load_s, mix_s, blk, 1'b0, '0);
            sent++;
         end else begin
            send_item(CMD_UNUSED, addr, load_s, mix_s, blk, 1'b0, '0);
         end
      end
   endtask

   // Result channel idling: random stall bursts, one long hold-off on request,
   // and none once the run has gone quiet.
   initial begin : result_idling
      rsp_stall <= 1'b0;
      @(negedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
   end

   // Each result transfer is compared with the oldest expected sample.
   always @(posedge clock) begin : result_check
      logic signed [15:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mixed_due.size() == 0) begin
            $error("mixed_sample: expected none, actual %0d", rsp_mixed_sample);
            fail_count++;
         end else begin
            want = mixed_due.pop_front();
            if (rsp_mixed_sample !== want) begin
               $error("mixed_sample: expected %0d, actual %0d", want, rsp_mixed_sample);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      plan_row_type plan [$];
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= CMD_LOAD;
      req_load_address <= '0;
      req_load_sample <= '0;
      req_mix_sample <= '0;
      req_block_start <= 1'b0;
      csr_write_en <= 1'b0;
      csr_index <= CSR_TRACK_LENGTH;
      csr_wdata <= '0;
      play_pos = 0;
      gain_now = INTENSITY_RESET;
      is_playing = 1'b0;
      cfg_length = 0;
      cfg_volume = VOLUME_RESET;
      cfg_target = INTENSITY_RESET;

      // Reset settings: nothing plays yet, so mixes pass straight through.
      plan.push_back(item_row(CMD_MIX, 16'h0000, 16'sh0000, 16'sh7FFF, 1'b0, 1'b1, 16'sh7FFF));
      plan.push_back(item_row(CMD_MIX, 16'h0000, 16'sh0000, 16'sh8000, 1'b1, 1'b1, 16'sh8000));
      plan.push_back(item_row(CMD_UNUSED, 16'hFFFF, 16'shFFFF, 16'shFFFF, 1'b1, 1'b0, '0));
      plan.push_back(item_row(CMD_LOAD, 16'h0000, 16'sh7FFF, 16'sh0000, 1'b0, 1'b0, '0));
      plan.push_back(item_row(CMD_LOAD, 16'h0001, 16'sh8000, 16'sh0000, 1'b0, 1'b0, '0));
      plan.push_back(item_row(CMD_LOAD, 16'h0002, 16'sh0000, 16'sh0000, 1'b0, 1'b0, '0));
      plan.push_back(item_row(CMD_LOAD, 16'hFFFF, 16'sh5A5A, 16'sh0000, 1'b0, 1'b0, '0));
      plan.push_back(item_row(CMD_START, 16'h0000, 16'sh0000, 16'sh0000, 1'b0, 1'b0, '0));
      // Playing with a zero track length still passes samples through.
      plan.push_back(item_row(CMD_MIX, 16'h0000, 16'sh0000, 16'sh1234, 1'b1, 1'b1, 16'sh1234));
      // Three-word track at full volume and unity gain: both rails saturate.
      plan.push_back(reg_row(CSR_TRACK_LENGTH, 3));
      plan.push_back(reg_row(CSR_MASTER_VOLUME, 100));
      plan.push_back(reg_row(CSR_TARGET_INTENSITY, INTENSITY_RESET));
      plan.push_back(item_row(CMD_START, 16'h0000, 16'sh0000, 16'sh0000, 1'b0, 1'b0, '0));
      plan.push_back(item_row(CMD_MIX, 16'h0000, 16'sh0000, 16'sh7FFF, 1'b0, 1'b1, 16'sh7FFF));
      plan.push_back(item_row(CMD_MIX, 16'h0000, 16'sh0000, 16'sh8000, 1'b0, 1'b1, 16'sh8000));
      plan.push_back(item_row(CMD_MIX, 16'h0000, 16'sh0000, 16'sh0000, 1'b0, 1'b1, 16'sh0000));
      // The position wraps back to the first word here.
      plan.push_back(item_row(CMD_MIX, 16'h0000, 16'sh0000, 16'sh0064, 1'b0, 1'b0, '0));
      // Volume above 100 and the gain ramping up toward the top target.
      plan.push_back(reg_row(CSR_MASTER_VOLUME, 127));
      plan.push_back(reg_row(CSR_TARGET_INTENSITY, 65535));
      plan.push_back(item_row(CMD_MIX, 16'h0000, 16'sh0000, 16'sh0100, 1'b1, 1'b0, '0));
      plan.push_back(item_row(CMD_MIX, 16'h0000, 16'sh0000, 16'shFF00, 1'b1, 1'b0, '0));
      plan.push_back(item_row(CMD_MIX, 16'h0000, 16'sh0000, 16'sh0000, 1'b0, 1'b0, '0));
      // Zero volume mutes the music while the gain ramps down.
      plan.push_back(reg_row(CSR_TARGET_INTENSITY, 0));
      plan.push_back(reg_row(CSR_MASTER_VOLUME, 0));
      plan.push_back(item_row(CMD_MIX, 16'h0000, 16'sh0000, 16'sh2222, 1'b1, 1'b1, 16'sh2222));
      // Longest track, restarted so that only loaded words are played.
      plan.push_back(reg_row(CSR_TRACK_LENGTH, 65536));
      plan.push_back(reg_row(CSR_MASTER_VOLUME, 100));
      plan.push_back(item_row(CMD_START, 16'h0000, 16'sh0000, 16'sh0000, 1'b0, 1'b0, '0));
      plan.push_back(item_row(CMD_MIX, 16'h0000, 16'sh0000, 16'sh4000, 1'b1, 1'b0, '0));
      plan.push_back(item_row(CMD_MIX, 16'h0000, 16'sh0000, 16'shC000, 1'b0, 1'b0, '0));

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table; registers change only once the block has gone idle.
      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            wait_idle();
            write_reg(plan[i].reg_index, plan[i].reg_value);
         end else begin
            send_item(plan[i].cmd, plan[i].addr, plan[i].load_s, plan[i].mix_s,
                      plan[i].blk, plan[i].typed, plan[i].typed_val);
         end
      end
      wait_idle();

      // Random phases, one with a long result hold-off, the last without idling.
      for (int p = 0; p < PHASES; p++) begin
         random_settings();
         if (p == 3) begin
            pressing = 1'b1;
            hold_pending = 1'b1;
         end
         if (p == PHASES - 1) quiet = 1'b1;
         random_phase(PHASE_ITEMS);
         pressing = 1'b0;
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin : run_limit
      #8_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
